// ----- src/rgv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgv_pkg
// Shared types and constants for the group-then-value rank assignment unit.
// ----------------------------------------------------------------------------
package rgv_pkg;

    localparam int VALUE_W    = 7;
    localparam int KEY_W      = 8;
    localparam int RANK_W     = 7;
    localparam int GROUP_SIZE = 8;
    localparam int PART_W     = 4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RANK,
        ST_EMIT
    } rgv_state_t;

    typedef struct packed {
        logic load;
        logic rank_wr;
        logic emit;
    } rgv_cmd_t;

    typedef struct packed {
        logic close_set;
        logic emit_last;
    } rgv_sts_t;

endpackage

// ----- src/rgv_ctrl.sv -----
// ----------------------------------------------------------------------------
// rgv_ctrl
// Sequencer: load an item, fold its rank, and after the set closes stream
// the ranks out in arrival order.
// ----------------------------------------------------------------------------
module rgv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rgv_pkg::rgv_sts_t sts,
    output rgv_pkg::rgv_cmd_t cmd
);

    rgv_pkg::rgv_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgv_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rgv_pkg::ST_LOAD: begin
                if (s_tvalid) begin
                    state_next = rgv_pkg::ST_RANK;
                end
            end
            rgv_pkg::ST_RANK: begin
                state_next = sts.close_set ? rgv_pkg::ST_EMIT : rgv_pkg::ST_LOAD;
            end
            rgv_pkg::ST_EMIT: begin
                if (m_tready && sts.emit_last) begin
                    state_next = rgv_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = rgv_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.rank_wr = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            rgv_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            rgv_pkg::ST_RANK: begin
                cmd.rank_wr = 1'b1;
            end
            rgv_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                cmd.emit = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/rgv_datapath.sv -----
// ----------------------------------------------------------------------------
// rgv_datapath
// Row of compare cells, one per item. Each cell holds a key and a running
// rank; a new key bumps every stored cell ordering after it, and its own rank
// comes from a registered count of the cells ordering at or before it.
// ----------------------------------------------------------------------------
module rgv_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rgv_pkg::rgv_cmd_t            cmd,
    output rgv_pkg::rgv_sts_t            sts,
    input  logic [rgv_pkg::VALUE_W-1:0]  item_value,
    input  logic                         group_flag,
    input  logic                         last_item,
    output logic [rgv_pkg::RANK_W-1:0]   new_rank,
    output logic                         last_rank
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int NG    = (MAX_ITEMS + rgv_pkg::GROUP_SIZE - 1) / rgv_pkg::GROUP_SIZE;
    localparam int PAD_W = NG * rgv_pkg::GROUP_SIZE;

    logic [rgv_pkg::KEY_W-1:0]  key_reg  [MAX_ITEMS];
    logic [CNT_W-1:0]           rank_reg [MAX_ITEMS];
    logic [rgv_pkg::PART_W-1:0] part_reg [NG];
    logic [rgv_pkg::PART_W-1:0] part_next[NG];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           emit_idx_reg;
    logic [IDX_W-1:0]           widx_reg;
    logic                       last_reg;

    logic [rgv_pkg::KEY_W-1:0]  new_key;
    logic [MAX_ITEMS-1:0]       le_vec;
    logic [MAX_ITEMS-1:0]       gt_vec;
    logic [PAD_W-1:0]           le_pad;
    logic [CNT_W-1:0]           rank_sum;

    assign new_key = {group_flag, item_value};

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            le_vec[i] = (CNT_W'(i) < count_reg) && (key_reg[i] <= new_key);
            gt_vec[i] = (CNT_W'(i) < count_reg) && (key_reg[i] > new_key);
        end
        le_pad = PAD_W'(le_vec);
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            part_next[g] = '0;
            for (int b = 0; b < rgv_pkg::GROUP_SIZE; b++) begin
                part_next[g] = part_next[g]
                             + rgv_pkg::PART_W'(le_pad[g * rgv_pkg::GROUP_SIZE + b]);
            end
        end
    end

    always_comb begin
        rank_sum = CNT_W'(1);
        for (int g = 0; g < NG; g++) begin
            rank_sum = rank_sum + CNT_W'(part_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg[count_reg[IDX_W-1:0]] <= new_key;
            widx_reg                      <= count_reg[IDX_W-1:0];
            for (int g = 0; g < NG; g++) begin
                part_reg[g] <= part_next[g];
            end
        end
    end

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        always_ff @(posedge aclk) begin
            priority if (cmd.emit) begin
                if (i == MAX_ITEMS - 1) begin
                    rank_reg[i] <= '0;
                end else begin
                    rank_reg[i] <= rank_reg[(i + 1) % MAX_ITEMS];
                end
            end else if (cmd.load && gt_vec[i]) begin
                rank_reg[i] <= rank_reg[i] + CNT_W'(1);
            end else if (cmd.rank_wr && (widx_reg == IDX_W'(i))) begin
                rank_reg[i] <= rank_sum;
            end else begin
                rank_reg[i] <= rank_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            emit_idx_reg <= '0;
            last_reg     <= 1'b0;
        end else begin
            if (cmd.load) begin
                count_reg <= count_reg + CNT_W'(1);
                last_reg  <= last_item;
            end
            if (cmd.emit) begin
                if (sts.emit_last) begin
                    count_reg    <= '0;
                    emit_idx_reg <= '0;
                end else begin
                    emit_idx_reg <= emit_idx_reg + CNT_W'(1);
                end
            end
        end
    end

    assign sts.close_set = last_reg || (count_reg == CNT_W'(MAX_ITEMS));
    assign sts.emit_last = (emit_idx_reg == count_reg - CNT_W'(1));

    assign new_rank  = rgv_pkg::RANK_W'(rank_reg[0]);
    assign last_rank = sts.emit_last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_no_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> count_reg < CNT_W'(MAX_ITEMS))
        else $error("item loaded into a full cell row");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rank_wr |-> (rank_sum != '0) && (rank_sum <= count_reg))
        else $error("computed rank outside the set");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && sts.emit_last |=> count_reg == '0 && emit_idx_reg == '0)
        else $error("set not cleared after final rank");

endmodule

// ----- src/group_then_value_rank_assign_unit.sv -----
// ----------------------------------------------------------------------------
// group_then_value_rank_assign_unit
// Ranks a set of items by group flag, then by value (stable on ties), and
// returns the ranks in arrival order.
// ----------------------------------------------------------------------------
// For each input transfer, the accept cycle compares the new key against every
// stored cell and registers per-group counts, and the next cycle adds those
// counts into the new item's rank. A set closes on tlast or when MAX_ITEMS
// items are held; its ranks then stream out one transfer per cycle while
// m_tready is high, from the head of the cell row, with tlast on the final
// one. No input is taken while a set is streaming out.
module group_then_value_rank_assign_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [6:0] item_value, [7] unused
    input  logic       s_tuser,   // group_flag
    input  logic       s_tlast,   // last_item
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] new_rank, [7] zero
    output logic       m_tlast    // last_rank
);

    rgv_pkg::rgv_cmd_t cmd;
    rgv_pkg::rgv_sts_t sts;
    logic [rgv_pkg::RANK_W-1:0] new_rank;

    rgv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rgv_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .item_value (s_tdata[rgv_pkg::VALUE_W-1:0]),
        .group_flag (s_tuser),
        .last_item  (s_tlast),
        .new_rank   (new_rank),
        .last_rank  (m_tlast)
    );

    assign m_tdata = {1'b0, new_rank};

endmodule
